[rtl/core/ptt_pkg.sv]
// Shared types and constants of the periodic timer table.
package ptt_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int DefNumTimers = 16;
  localparam int DefTimeBits  = 48;

  // Fixed field widths of the item ports, the skip count limit and the command queue depth.
  localparam int SlotW    = 4;
  localparam int SkipW    = 16;
  localparam int SkipMax  = 65535;
  localparam int CmdDepth = 2;

  // Input mode codes.
  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_EXEC   = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BUSY        = 2'd1,
    ST_EMPTY       = 2'd2,
    ST_ZERO_PERIOD = 2'd3
  } status_e;

  // Classified command kinds handed from the front to the back.
  typedef enum logic [2:0] {
    OP_ADD,
    OP_REMOVE,
    OP_EXEC,
    OP_QUERY,
    OP_REJECT
  } op_e;

  // Control part of a queued command.
  typedef struct packed {
    op_e                op;
    status_e            status;
    logic [SlotW-1:0]   slot;
    logic               fire_once;
  } ctl_t;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    B_IDLE,
    B_ADD,
    B_REM,
    B_REJ,
    B_XRD,
    B_XCHK,
    B_XDIV,
    B_XPUSH,
    B_XEND,
    B_QRD,
    B_QCHK,
    B_QOUT
  } bst_e;

endpackage

[rtl/core/periodic_timer_table_top.sv]
// Top level of the periodic timer table.
// The block keeps NUM_TIMERS timer slots and takes add, remove, execute and
// query items through a two-entry command queue, so a new item is accepted
// while the back end still works or a result waits at the output, as long as
// the queue has room. Query reads the slot table one entry at a time through
// its registered read port. Execute scans the table the same way and, for each
// periodic slot that fires, runs the one-bit-per-cycle divider that counts
// skipped periods before the result hand-off; an execute returns one result
// per fired slot in ascending order, or a single non-fired result, and the
// final result carries last. No clearing pass is needed after reset.
module periodic_timer_table_top import ptt_pkg::*; #(
  parameter int NUM_TIMERS = DefNumTimers,
  parameter int TIME_BITS  = DefTimeBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           mode_i,
  input  logic [SlotW-1:0]     slot_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [TIME_BITS-1:0] delay_i,
  input  logic [TIME_BITS-1:0] period_i,
  input  logic                 fire_once_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic                 fired_o,
  output logic [SlotW-1:0]     fired_slot_o,
  output logic [SkipW-1:0]     skipped_periods_o,
  output logic [TIME_BITS-1:0] next_expiry_o,
  output logic                 any_timers_o,
  output logic                 last_o
);

  localparam int CmdW = $bits(ctl_t) + 3 * TIME_BITS;

  logic            q_push, q_full, q_pop, q_empty;
  logic [CmdW-1:0] q_wdata, q_rdata;

  ptt_front #(
    .TIME_BITS (TIME_BITS),
    .CMD_W     (CmdW)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .slot_i      (slot_i),
    .now_i       (now_i),
    .delay_i     (delay_i),
    .period_i    (period_i),
    .fire_once_i (fire_once_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  ptt_fifo #(
    .DATA_W (CmdW),
    .DEPTH  (CmdDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  ptt_back #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_BITS  (TIME_BITS),
    .CMD_W      (CmdW)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_data_i          (q_rdata),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .fired_o           (fired_o),
    .fired_slot_o      (fired_slot_o),
    .skipped_periods_o (skipped_periods_o),
    .next_expiry_o     (next_expiry_o),
    .any_timers_o      (any_timers_o),
    .last_o            (last_o)
  );

endmodule

[rtl/core/ptt_front.sv]
// Front end: accepts items, classifies them and forms the first expiry sum.
module ptt_front import ptt_pkg::*; #(
  parameter int TIME_BITS = DefTimeBits,
  parameter int CMD_W     = $bits(ctl_t) + 3 * DefTimeBits
) (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           mode_i,
  input  logic [SlotW-1:0]     slot_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [TIME_BITS-1:0] delay_i,
  input  logic [TIME_BITS-1:0] period_i,
  input  logic                 fire_once_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output logic [CMD_W-1:0]     q_data_o
);

  typedef struct packed {
    ctl_t                 ctl;
    logic [TIME_BITS-1:0] time_a;
    logic [TIME_BITS-1:0] delay;
    logic [TIME_BITS-1:0] period;
  } cmd_t;

  cmd_t               cmd;
  logic [TIME_BITS:0] sum;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify the mode, reject an add with a zero period and saturate now plus period for an add.
  always_comb begin
    sum               = {1'b0, now_i} + {1'b0, period_i};
    cmd.ctl.slot      = slot_i;
    cmd.ctl.fire_once = fire_once_i;
    cmd.ctl.status    = ST_OK;
    cmd.delay         = delay_i;
    cmd.period        = period_i;
    cmd.time_a        = now_i;
    case (mode_e'(mode_i))
      MODE_ADD: begin
        if (period_i == '0) begin
          cmd.ctl.op     = OP_REJECT;
          cmd.ctl.status = ST_ZERO_PERIOD;
        end else begin
          cmd.ctl.op = OP_ADD;
          cmd.time_a = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        end
      end
      MODE_REMOVE: cmd.ctl.op = OP_REMOVE;
      MODE_EXEC:   cmd.ctl.op = OP_EXEC;
      MODE_QUERY:  cmd.ctl.op = OP_QUERY;
      default:     cmd.ctl.op = OP_QUERY;
    endcase
  end

  assign q_data_o = CMD_W'(cmd);

endmodule

[rtl/core/ptt_fifo.sv]
// Short command queue between the front end and the back end.
module ptt_fifo import ptt_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = CmdDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Pointer and fill count updates with wrap at the depth.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[rtl/core/ptt_div.sv]
// Restoring divider, one quotient bit per cycle, for the skipped period count.
module ptt_div import ptt_pkg::*; #(
  parameter int W = DefTimeBits
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int CntW = $clog2(W + 1);

  logic [W-1:0]    quo_q, rem_q, dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [W:0]      shifted;
  logic [W+1:0]    diff;

  // One trial subtraction of the shifted partial remainder.
  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[W+1]) begin
        rem_q <= diff[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

[rtl/core/ptt_back.sv]
// Back end: slot table, command sequencer and result register.
module ptt_back import ptt_pkg::*; #(
  parameter int NUM_TIMERS = DefNumTimers,
  parameter int TIME_BITS  = DefTimeBits,
  parameter int CMD_W      = $bits(ctl_t) + 3 * DefTimeBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  logic [CMD_W-1:0]     q_data_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic                 fired_o,
  output logic [SlotW-1:0]     fired_slot_o,
  output logic [SkipW-1:0]     skipped_periods_o,
  output logic [TIME_BITS-1:0] next_expiry_o,
  output logic                 any_timers_o,
  output logic                 last_o
);

  localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  typedef struct packed {
    ctl_t                 ctl;
    logic [TIME_BITS-1:0] time_a;
    logic [TIME_BITS-1:0] delay;
    logic [TIME_BITS-1:0] period;
  } cmd_t;

  bst_e                  state_q, state_d;
  cmd_t                  cur_q, cur_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [NUM_TIMERS-1:0] valid_q, valid_d;
  logic                  pend_v_q, pend_v_d;
  logic [IdxW-1:0]       pend_slot_q, pend_slot_d, new_slot_q, new_slot_d;
  logic [SkipW-1:0]      pend_skip_q, pend_skip_d, new_skip_q, new_skip_d;
  logic [TIME_BITS-1:0]  best_q, best_d;
  logic                  any_q, any_d;

  // Slot table memories with registered read at the scan index.
  logic [TIME_BITS-1:0]  per_mem [NUM_TIMERS];
  logic [TIME_BITS-1:0]  nt_mem  [NUM_TIMERS];
  logic                  os_mem  [NUM_TIMERS];
  logic [TIME_BITS-1:0]  rd_per_q, rd_nt_q;
  logic                  rd_os_q;
  logic                  mem_we, mem_wfull;
  logic [IdxW-1:0]       mem_wa;
  logic [TIME_BITS-1:0]  mem_wnt;

  // Result register.
  logic                  ov_q, ov_d, out_free;
  status_e               ost_q, ost_d;
  logic                  ofi_q, ofi_d, oany_q, oany_d, olast_q, olast_d;
  logic [SlotW-1:0]      oslot_q, oslot_d;
  logic [SkipW-1:0]      oskip_q, oskip_d;
  logic [TIME_BITS-1:0]  oexp_q, oexp_d;

  // Divider and datapath terms.
  logic                  div_start, div_done;
  logic [TIME_BITS-1:0]  div_quot, div_rem;
  logic [TIME_BITS:0]    exp_sum, upd_sum;
  logic [IdxW-1:0]       sidx;
  logic                  in_range, last_idx, hit;
  cmd_t                  head;

  assign head     = cmd_t'(q_data_i);
  assign out_free = !ov_q || out_ready_i;
  assign sidx     = IdxW'(cur_q.ctl.slot);
  assign in_range = (32'(cur_q.ctl.slot) < NUM_TIMERS);
  assign last_idx = (idx_q == IdxW'(NUM_TIMERS - 1));
  assign hit      = valid_q[idx_q] && (rd_nt_q <= cur_q.time_a);
  assign exp_sum  = {1'b0, cur_q.time_a} + {1'b0, cur_q.delay};
  // The next expiry past now is now minus the remainder plus one period.
  assign upd_sum  = {1'b0, cur_q.time_a} - {1'b0, div_rem} + {1'b0, rd_per_q};

  ptt_div #(
    .W (TIME_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cur_q.time_a - rd_nt_q),
    .divisor_i  (rd_per_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          case (head.ctl.op)
            OP_ADD:    state_d = B_ADD;
            OP_REMOVE: state_d = B_REM;
            OP_EXEC:   state_d = B_XRD;
            OP_QUERY:  state_d = B_QRD;
            default:   state_d = B_REJ;
          endcase
        end
      end
      B_ADD, B_REM, B_REJ, B_XEND, B_QOUT: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      B_XRD: state_d = B_XCHK;
      B_XCHK: begin
        if (!hit) begin
          state_d = last_idx ? B_XEND : B_XRD;
        end else if (rd_os_q) begin
          state_d = B_XPUSH;
        end else begin
          state_d = B_XDIV;
        end
      end
      B_XDIV: begin
        if (div_done) begin
          state_d = B_XPUSH;
        end
      end
      B_XPUSH: begin
        if (!pend_v_q || out_free) begin
          state_d = last_idx ? B_XEND : B_XRD;
        end
      end
      B_QRD:  state_d = B_QCHK;
      B_QCHK: state_d = last_idx ? B_QOUT : B_QRD;
      default: state_d = B_IDLE;
    endcase
  end

  // Datapath, table writes and result loads.
  always_comb begin
    q_pop_o     = 1'b0;
    cur_d       = cur_q;
    idx_d       = idx_q;
    valid_d     = valid_q;
    pend_v_d    = pend_v_q;
    pend_slot_d = pend_slot_q;
    pend_skip_d = pend_skip_q;
    new_slot_d  = new_slot_q;
    new_skip_d  = new_skip_q;
    best_d      = best_q;
    any_d       = any_q;
    mem_we      = 1'b0;
    mem_wfull   = 1'b0;
    mem_wa      = sidx;
    mem_wnt     = exp_sum[TIME_BITS] ? '1 : exp_sum[TIME_BITS-1:0];
    div_start   = 1'b0;
    ov_d        = ov_q && !out_ready_i;
    ost_d       = ost_q;
    ofi_d       = ofi_q;
    oany_d      = oany_q;
    olast_d     = olast_q;
    oslot_d     = oslot_q;
    oskip_d     = oskip_q;
    oexp_d      = oexp_q;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o  = 1'b1;
          cur_d    = head;
          idx_d    = '0;
          pend_v_d = 1'b0;
          best_d   = '1;
          any_d    = 1'b0;
        end
      end
      B_ADD: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ofi_d   = 1'b0;
          oslot_d = '0;
          oskip_d = '0;
          oexp_d  = '0;
          oany_d  = 1'b0;
          olast_d = 1'b1;
          if (!in_range || valid_q[sidx]) begin
            ost_d = ST_BUSY;
          end else begin
            ost_d         = ST_OK;
            mem_we        = 1'b1;
            mem_wfull     = 1'b1;
            valid_d[sidx] = 1'b1;
          end
        end
      end
      B_REM: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ofi_d   = 1'b0;
          oslot_d = '0;
          oskip_d = '0;
          oexp_d  = '0;
          oany_d  = 1'b0;
          olast_d = 1'b1;
          if (in_range && valid_q[sidx]) begin
            ost_d         = ST_OK;
            valid_d[sidx] = 1'b0;
          end else begin
            ost_d = ST_EMPTY;
          end
        end
      end
      B_REJ: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ost_d   = cur_q.ctl.status;
          ofi_d   = 1'b0;
          oslot_d = '0;
          oskip_d = '0;
          oexp_d  = '0;
          oany_d  = 1'b0;
          olast_d = 1'b1;
        end
      end
      B_XCHK: begin
        if (!hit) begin
          if (!last_idx) begin
            idx_d = idx_q + 1'b1;
          end
        end else if (rd_os_q) begin
          valid_d[idx_q] = 1'b0;
          new_slot_d     = idx_q;
          new_skip_d     = '0;
        end else begin
          div_start = 1'b1;
        end
      end
      B_XDIV: begin
        if (div_done) begin
          mem_we     = 1'b1;
          mem_wa     = idx_q;
          mem_wnt    = upd_sum[TIME_BITS] ? '1 : upd_sum[TIME_BITS-1:0];
          new_slot_d = idx_q;
          new_skip_d = (div_quot > TIME_BITS'(SkipMax)) ? '1 : div_quot[SkipW-1:0];
        end
      end
      B_XPUSH: begin
        // Hold back one fired result so the final one can carry last.
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            ov_d    = 1'b1;
            ost_d   = ST_OK;
            ofi_d   = 1'b1;
            oslot_d = SlotW'(pend_slot_q);
            oskip_d = pend_skip_q;
            oexp_d  = '0;
            oany_d  = 1'b0;
            olast_d = 1'b0;
          end
          pend_v_d    = 1'b1;
          pend_slot_d = new_slot_q;
          pend_skip_d = new_skip_q;
          if (!last_idx) begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      B_XEND: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ost_d   = ST_OK;
          ofi_d   = pend_v_q;
          oslot_d = pend_v_q ? SlotW'(pend_slot_q) : '0;
          oskip_d = pend_v_q ? pend_skip_q : '0;
          oexp_d  = '0;
          oany_d  = 1'b0;
          olast_d = 1'b1;
        end
      end
      B_QCHK: begin
        if (valid_q[idx_q]) begin
          any_d = 1'b1;
          if (rd_nt_q < best_q) begin
            best_d = rd_nt_q;
          end
        end
        if (!last_idx) begin
          idx_d = idx_q + 1'b1;
        end
      end
      B_QOUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ost_d   = ST_OK;
          ofi_d   = 1'b0;
          oslot_d = '0;
          oskip_d = '0;
          oexp_d  = best_q;
          oany_d  = any_q;
          olast_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      valid_q  <= '0;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      pend_v_q <= pend_v_d;
      ov_q     <= ov_d;
      idx_q    <= idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    pend_slot_q <= pend_slot_d;
    pend_skip_q <= pend_skip_d;
    new_slot_q  <= new_slot_d;
    new_skip_q  <= new_skip_d;
    best_q      <= best_d;
    any_q       <= any_d;
    ost_q       <= ost_d;
    ofi_q       <= ofi_d;
    oany_q      <= oany_d;
    olast_q     <= olast_d;
    oslot_q     <= oslot_d;
    oskip_q     <= oskip_d;
    oexp_q      <= oexp_d;
  end

  // Table write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      nt_mem[mem_wa] <= mem_wnt;
      if (mem_wfull) begin
        per_mem[mem_wa] <= cur_q.period;
        os_mem[mem_wa]  <= cur_q.ctl.fire_once;
      end
    end
    rd_nt_q  <= nt_mem[idx_q];
    rd_per_q <= per_mem[idx_q];
    rd_os_q  <= os_mem[idx_q];
  end

  assign out_valid_o       = ov_q;
  assign status_o          = ost_q;
  assign fired_o           = ofi_q;
  assign fired_slot_o      = oslot_q;
  assign skipped_periods_o = oskip_q;
  assign next_expiry_o     = oexp_q;
  assign any_timers_o      = oany_q;
  assign last_o            = olast_q;

endmodule
